>>> hw/rtl/sdct_pkg.sv
// shared types and constants for the sd spi command transactor
package sdct_pkg;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 12;

  localparam logic [CfgIdxW-1:0] CfgReadyPollLimit = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgRespPollLimit  = 1'b1;

  localparam logic [11:0] ReadyLimitReset = 12'hFFF;
  localparam logic [7:0]  RespLimitReset  = 8'd10;

  localparam logic OpStart = 1'b0;
  localparam logic OpByte  = 1'b1;

  localparam logic [1:0] OutcomeResp    = 2'd0;
  localparam logic [1:0] OutcomeTimeout = 2'd1;
  localparam logic [1:0] OutcomeAppRej  = 2'd2;

  localparam logic [7:0] DummyByte   = 8'hFF;
  localparam logic [7:0] CmdStartBit = 8'h40;
  localparam logic [7:0] CrcCmd0     = 8'h95;
  localparam logic [7:0] CrcCmd8     = 8'h87;
  localparam logic [7:0] CrcDefault  = 8'h01;
  localparam logic [5:0] Cmd0        = 6'd0;
  localparam logic [5:0] Cmd8        = 6'd8;
  localparam logic [5:0] AppCmd      = 6'd55;

  typedef struct packed {
    logic        operation;
    logic [5:0]  command_index;
    logic        app_command;
    logic [31:0] argument;
    logic [7:0]  rx_byte;
  } req_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       select_low;
    logic       done_res;
    logic [1:0] outcome;
    logic [7:0] response;
  } res_t;

endpackage

>>> hw/rtl/sdct_if.sv
// valid/ready channels for requests and results

interface sdct_req_if;
  logic               valid;
  logic               ready;
  sdct_pkg::req_t     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface sdct_res_if;
  logic               valid;
  logic               ready;
  sdct_pkg::res_t     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/sd_spi_command_transactor.sv
// Host side of one SD SPI-mode command: each request is one byte exchange on the
// serial link and yields one result (next byte to send, chip-select level, done
// status). A request is taken in every clock cycle while the result register is
// empty or its content is being taken in the same cycle; the result, computed by the
// phase state machine in a single pass, is registered and valid in the cycle after. The
// user must write poll limits via the cfg port only while no transaction is running; the block does not enforce it.
module sd_spi_command_transactor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sdct_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sdct_pkg::CfgDataW-1:0] cfg_data_i,
  sdct_req_if.sink                      req,
  sdct_res_if.source                    res
);
  import sdct_pkg::*;

  localparam logic [2:0] PhIdleRel  = 3'd0;
  localparam logic [2:0] PhIdleSel  = 3'd1;
  localparam logic [2:0] PhDesel    = 3'd2;
  localparam logic [2:0] PhSelDummy = 3'd3;
  localparam logic [2:0] PhReady    = 3'd4;
  localparam logic [2:0] PhTimeout  = 3'd5;
  localparam logic [2:0] PhFrame    = 3'd6;
  localparam logic [2:0] PhResp     = 3'd7;

  logic [11:0] rdy_lim_q;
  logic [7:0]  rsp_lim_q;

  logic [2:0]  phase_q, phase_d;
  logic [11:0] poll_q, poll_d;
  logic [2:0]  fidx_q, fidx_d;
  logic [5:0]  cmd_q, cmd_d;
  logic [31:0] arg_q, arg_d;
  logic        prefix_q, prefix_d;
  logic [7:0]  last_q, last_d;

  res_t        out_q, out_d;
  logic        out_valid_q;
  logic        accept;

  logic [5:0]  frame_cmd;
  logic [31:0] frame_arg;
  logic [7:0]  frame_crc;

  function automatic logic [7:0] frame_sel(input logic [2:0] idx, input logic [5:0] cmd,
                                           input logic [31:0] arg, input logic [7:0] crc);
    logic [7:0] b;
    case (idx)
      3'd0:    b = CmdStartBit | {2'b00, cmd};
      3'd1:    b = arg[31:24];
      3'd2:    b = arg[23:16];
      3'd3:    b = arg[15:8];
      3'd4:    b = arg[7:0];
      default: b = crc;
    endcase
    return b;
  endfunction

  assign req.ready = !out_valid_q || res.ready;
  assign accept    = req.valid && req.ready;
  assign res.valid   = out_valid_q;
  assign res.payload = out_q;

  // the cmd55 prefix goes out with a zero argument
  assign frame_cmd = prefix_q ? AppCmd : cmd_q;
  assign frame_arg = prefix_q ? 32'd0 : arg_q;
  always_comb begin
    if (frame_cmd == Cmd0) begin
      frame_crc = CrcCmd0;
    end else if (frame_cmd == Cmd8) begin
      frame_crc = CrcCmd8;
    end else begin
      frame_crc = CrcDefault;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    poll_d   = poll_q;
    fidx_d   = fidx_q;
    cmd_d    = cmd_q;
    arg_d    = arg_q;
    prefix_d = prefix_q;
    last_d   = last_q;
    out_d    = '{tx_valid: 1'b1, tx_byte: DummyByte, select_low: 1'b1, done_res: 1'b0,
                 outcome: OutcomeResp, response: 8'd0};

    if (req.payload.operation == OpStart) begin
      cmd_d    = req.payload.command_index;
      prefix_d = req.payload.app_command;
      arg_d    = req.payload.argument;
      last_d   = DummyByte;
      poll_d   = 12'd0;
      fidx_d   = 3'd0;
      phase_d  = PhDesel;
      out_d.select_low = 1'b0;
    end else begin
      case (phase_q)
        PhDesel: begin
          phase_d = PhSelDummy;
        end
        PhSelDummy: begin
          phase_d = PhReady;
          poll_d  = 12'd1;
        end
        PhReady: begin
          if (req.payload.rx_byte == DummyByte) begin
            phase_d = PhFrame;
            out_d.tx_byte = frame_sel(3'd0, frame_cmd, frame_arg, frame_crc);
            fidx_d  = 3'd1;
          end else if (poll_q >= rdy_lim_q) begin
            phase_d = PhTimeout;
            out_d.select_low = 1'b0;
          end else begin
            poll_d = poll_q + 12'd1;
          end
        end
        PhTimeout: begin
          phase_d  = PhIdleRel;
          prefix_d = 1'b0;
          out_d.tx_valid   = 1'b0;
          out_d.select_low = 1'b0;
          out_d.done_res   = 1'b1;
          out_d.outcome    = OutcomeTimeout;
          out_d.response   = last_q;
        end
        PhFrame: begin
          if (fidx_q <= 3'd5) begin
            out_d.tx_byte = frame_sel(fidx_q, frame_cmd, frame_arg, frame_crc);
            fidx_d = fidx_q + 3'd1;
          end else begin
            phase_d = PhResp;
            poll_d  = 12'd1;
          end
        end
        PhResp: begin
          if (req.payload.rx_byte[7] && (poll_q < {4'd0, rsp_lim_q})) begin
            poll_d = poll_q + 12'd1;
          end else begin
            last_d = req.payload.rx_byte;
            if (prefix_q) begin
              prefix_d = 1'b0;
              if (req.payload.rx_byte > 8'd1) begin
                phase_d = PhIdleSel;
                out_d.tx_valid = 1'b0;
                out_d.done_res = 1'b1;
                out_d.outcome  = OutcomeAppRej;
                out_d.response = req.payload.rx_byte;
              end else begin
                // prefix accepted, rerun the sequence for the real command
                phase_d = PhDesel;
                poll_d  = 12'd0;
                fidx_d  = 3'd0;
                out_d.select_low = 1'b0;
              end
            end else begin
              phase_d = PhIdleSel;
              out_d.tx_valid = 1'b0;
              out_d.done_res = 1'b1;
              out_d.response = req.payload.rx_byte;
            end
          end
        end
        PhIdleSel: begin
          out_d.tx_valid = 1'b0;
        end
        default: begin
          phase_d = PhIdleRel;
          out_d.tx_valid   = 1'b0;
          out_d.select_low = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdy_lim_q <= ReadyLimitReset;
      rsp_lim_q <= RespLimitReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgReadyPollLimit: rdy_lim_q <= cfg_data_i[11:0];
        CfgRespPollLimit:  rsp_lim_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdleRel;
      poll_q      <= 12'd0;
      fidx_q      <= 3'd0;
      cmd_q       <= 6'd0;
      arg_q       <= 32'd0;
      prefix_q    <= 1'b0;
      last_q      <= DummyByte;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q  <= phase_d;
        poll_q   <= poll_d;
        fidx_q   <= fidx_d;
        cmd_q    <= cmd_d;
        arg_q    <= arg_d;
        prefix_q <= prefix_d;
        last_q   <= last_d;
        out_valid_q <= 1'b1;
      end else if (res.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

endmodule

>>> sim/sd_spi_command_transactor_tb.sv
// self-checking testbench for the sd spi command transactor
module sd_spi_command_transactor_tb;
  import sdct_pkg::*;

  typedef enum logic [3:0] {
    PhIdleRel, PhIdleSel, PhDesel, PhSelDummy, PhReady, PhTout, PhFrame, PhResp
  } xact_phase_e;

  class spi_cmd_scoreboard;
    xact_phase_e phase;
    logic [11:0] poll_count;
    logic [2:0]  frame_idx;
    logic [5:0]  held_cmd;
    logic [31:0] held_arg;
    logic        prefix_pending;
    logic [7:0]  last_r1;
    logic [11:0] ready_limit;
    logic [7:0]  resp_limit;
    res_t        expected_replies[$];
    int unsigned errors, checked, n_started, n_resp, n_tout, n_rej;

    function new();
      ready_limit = ReadyLimitReset;
      resp_limit = RespLimitReset;
      phase = PhIdleRel;
      poll_count = '0;
      frame_idx = '0;
      held_cmd = '0;
      held_arg = '0;
      prefix_pending = 1'b0;
      last_r1 = 8'hFF;
    endfunction

    function void write_limit(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == CfgReadyPollLimit) begin
        ready_limit = data[11:0];
      end else begin
        resp_limit = data[7:0];
      end
    endfunction

    function res_t make_reply(logic valid, logic [7:0] tx, logic sel, logic done,
                              logic [1:0] outc, logic [7:0] resp);
      res_t r;
      r.tx_valid = valid;
      r.tx_byte = tx;
      r.select_low = sel;
      r.done_res = done;
      r.outcome = outc;
      r.response = resp;
      return r;
    endfunction

    // the cmd55 prefix goes out with a zero argument
    function logic [7:0] frame_byte(logic [2:0] idx);
      logic [5:0]  c;
      logic [31:0] a;
      c = prefix_pending ? AppCmd : held_cmd;
      a = prefix_pending ? 32'h0 : held_arg;
      case (idx)
        3'd0: return CmdStartBit | {2'b00, c};
        3'd1: return a[31:24];
        3'd2: return a[23:16];
        3'd3: return a[15:8];
        3'd4: return a[7:0];
        default: begin
          if (c == Cmd0) return CrcCmd0;
          if (c == Cmd8) return CrcCmd8;
          return CrcDefault;
        end
      endcase
    endfunction

    // returns 0 when the request was a byte the block ignores while idle
    function bit note_request(req_t rq);
      res_t r;
      bit   live;
      live = 1'b1;
      if (rq.operation == OpStart) begin
        held_cmd = rq.command_index;
        prefix_pending = rq.app_command;
        held_arg = rq.argument;
        last_r1 = 8'hFF;
        poll_count = '0;
        frame_idx = '0;
        phase = PhDesel;
        n_started++;
        r = make_reply(1'b1, DummyByte, 1'b0, 1'b0, OutcomeResp, 8'h00);
      end else begin
        case (phase)
          PhDesel: begin
            phase = PhSelDummy;
            r = make_reply(1'b1, DummyByte, 1'b1, 1'b0, OutcomeResp, 8'h00);
          end
          PhSelDummy: begin
            phase = PhReady;
            poll_count = 12'd1;
            r = make_reply(1'b1, DummyByte, 1'b1, 1'b0, OutcomeResp, 8'h00);
          end
          PhReady: begin
            if (rq.rx_byte == 8'hFF) begin
              phase = PhFrame;
              r = make_reply(1'b1, frame_byte(3'd0), 1'b1, 1'b0, OutcomeResp, 8'h00);
              frame_idx = 3'd1;
            end else if (poll_count >= ready_limit) begin
              phase = PhTout;
              r = make_reply(1'b1, DummyByte, 1'b0, 1'b0, OutcomeResp, 8'h00);
            end else begin
              poll_count = poll_count + 12'd1;
              r = make_reply(1'b1, DummyByte, 1'b1, 1'b0, OutcomeResp, 8'h00);
            end
          end
          PhTout: begin
            phase = PhIdleRel;
            prefix_pending = 1'b0;
            n_tout++;
            r = make_reply(1'b0, DummyByte, 1'b0, 1'b1, OutcomeTimeout, last_r1);
          end
          PhFrame: begin
            if (frame_idx <= 3'd5) begin
              r = make_reply(1'b1, frame_byte(frame_idx), 1'b1, 1'b0, OutcomeResp, 8'h00);
              frame_idx = frame_idx + 3'd1;
            end else begin
              phase = PhResp;
              poll_count = 12'd1;
              r = make_reply(1'b1, DummyByte, 1'b1, 1'b0, OutcomeResp, 8'h00);
            end
          end
          PhResp: begin
            if (rq.rx_byte[7] && ({4'h0, poll_count} < {8'h00, resp_limit})) begin
              poll_count = poll_count + 12'd1;
              r = make_reply(1'b1, DummyByte, 1'b1, 1'b0, OutcomeResp, 8'h00);
            end else begin
              last_r1 = rq.rx_byte;
              if (prefix_pending) begin
                prefix_pending = 1'b0;
                if (rq.rx_byte > 8'd1) begin
                  phase = PhIdleSel;
                  n_rej++;
                  r = make_reply(1'b0, DummyByte, 1'b1, 1'b1, OutcomeAppRej, rq.rx_byte);
                end else begin
                  // prefix accepted: run the real command from the deselect on
                  phase = PhDesel;
                  poll_count = '0;
                  frame_idx = '0;
                  r = make_reply(1'b1, DummyByte, 1'b0, 1'b0, OutcomeResp, 8'h00);
                end
              end else begin
                phase = PhIdleSel;
                n_resp++;
                r = make_reply(1'b0, DummyByte, 1'b1, 1'b1, OutcomeResp, rq.rx_byte);
              end
            end
          end
          PhIdleSel: begin
            live = 1'b0;
            r = make_reply(1'b0, DummyByte, 1'b1, 1'b0, OutcomeResp, 8'h00);
          end
          default: begin
            live = 1'b0;
            phase = PhIdleRel;
            r = make_reply(1'b0, DummyByte, 1'b0, 1'b0, OutcomeResp, 8'h00);
          end
        endcase
      end
      expected_replies.push_back(r);
      return live;
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_reply(res_t got);
      res_t want;
      if (expected_replies.size() == 0) begin
        $error("reply %h arrived with no request waiting", got);
        errors++;
        return;
      end
      want = expected_replies.pop_front();
      checked++;
      compare("tx_valid", {7'h0, want.tx_valid}, {7'h0, got.tx_valid});
      compare("tx_byte", want.tx_byte, got.tx_byte);
      compare("select_low", {7'h0, want.select_low}, {7'h0, got.select_low});
      compare("done_res", {7'h0, want.done_res}, {7'h0, got.done_res});
      compare("outcome", {6'h0, want.outcome}, {6'h0, got.outcome});
      compare("response", want.response, got.response);
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  sdct_req_if req_ch ();
  sdct_res_if res_ch ();

  sd_spi_command_transactor u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .req         (req_ch),
    .res         (res_ch)
  );

  spi_cmd_scoreboard sb = new();

  int unsigned send_idle_pct = 24;
  int unsigned recv_idle_pct = 88;
  int unsigned counted_items = 0;
  int unsigned idle_bytes = 0;
  int unsigned cut_short = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: check on every accepted reply, stall at random
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_ch.valid === 1'b1 && res_ch.ready) begin
        sb.check_reply(res_ch.payload);
      end
      res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic req_t noise_request();
    req_t rq;
    rq.operation = 1'($urandom_range(0, 1));
    rq.command_index = 6'($urandom_range(0, 63));
    rq.app_command = 1'($urandom_range(0, 1));
    rq.argument = $urandom;
    rq.rx_byte = 8'($urandom_range(0, 255));
    return rq;
  endfunction

  // valid stays high from one request to the next unless a gap is taken
  task automatic send_item(req_t rq);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    req_ch.valid <= 1'b1;
    req_ch.payload <= rq;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    if (sb.note_request(rq)) begin
      counted_items++;
    end else begin
      idle_bytes++;
    end
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (sb.expected_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_limits(logic [11:0] ready_lim, logic [7:0] resp_lim);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CfgReadyPollLimit;
    cfg_data_i <= ready_lim;
    @(posedge clk_i);
    sb.write_limit(CfgReadyPollLimit, ready_lim);
    cfg_index_i <= CfgRespPollLimit;
    cfg_data_i <= {4'h0, resp_lim};
    @(posedge clk_i);
    sb.write_limit(CfgRespPollLimit, {4'h0, resp_lim});
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_idle_bytes(int unsigned n);
    req_t rq;
    repeat (n) begin
      rq = noise_request();
      rq.operation = OpByte;
      send_item(rq);
    end
  endtask

  // one command as a cooperating card would answer it: ready_busy non-0xFF
  // bytes before ready, resp_busy bytes with bit 7 set before each R1
  task automatic run_command(logic [5:0] cmd, logic app, logic [31:0] arg,
                             int unsigned cut_after, int unsigned ready_busy,
                             int unsigned resp_busy, logic [7:0] r1_prefix,
                             logic [7:0] r1_final);
    req_t        rq;
    int unsigned ready_left, resp_left, sent;
    rq = noise_request();
    rq.operation = OpStart;
    rq.command_index = cmd;
    rq.app_command = app;
    rq.argument = arg;
    send_item(rq);
    sent = 1;
    ready_left = ready_busy;
    resp_left = resp_busy;
    while (sb.phase != PhIdleRel && sb.phase != PhIdleSel) begin
      if (cut_after != 0 && sent >= cut_after) begin
        cut_short++;
        return;
      end
      rq = noise_request();
      rq.operation = OpByte;
      case (sb.phase)
        PhDesel: begin
          ready_left = ready_busy;
          resp_left = resp_busy;
        end
        PhReady: begin
          if (ready_left > 0) begin
            rq.rx_byte = 8'($urandom_range(0, 254));
            ready_left--;
          end else begin
            rq.rx_byte = 8'hFF;
          end
        end
        PhResp: begin
          if (resp_left > 0) begin
            rq.rx_byte = 8'h80 | 8'($urandom_range(0, 127));
            resp_left--;
          end else begin
            rq.rx_byte = sb.prefix_pending ? r1_prefix : r1_final;
          end
        end
        default: ;
      endcase
      send_item(rq);
      sent++;
    end
  endtask

  task automatic random_command();
    int unsigned eff_ready, eff_resp, ready_busy, resp_busy, cut_after;
    logic [5:0]  cmd;
    logic [7:0]  r1_prefix;
    eff_ready = (sb.ready_limit == 0) ? 1 : sb.ready_limit;
    eff_resp = (sb.resp_limit == 0) ? 1 : sb.resp_limit;
    if ($urandom_range(0, 5) == 0 && eff_ready <= 64) begin
      ready_busy = eff_ready + $urandom_range(0, 2);
    end else begin
      ready_busy = $urandom_range(0, 3);
    end
    if ($urandom_range(0, 5) == 0 && eff_resp <= 64) begin
      resp_busy = eff_resp + $urandom_range(0, 2);
    end else begin
      resp_busy = $urandom_range(0, 2);
    end
    case ($urandom_range(0, 7))
      0: cmd = Cmd0;
      1: cmd = Cmd8;
      default: cmd = 6'($urandom_range(0, 63));
    endcase
    r1_prefix = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(2, 127))
                                              : 8'($urandom_range(0, 1));
    cut_after = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 14) : 0;
    if ($urandom_range(0, 9) == 0) wait_drained();
    run_command(cmd, ($urandom_range(0, 2) == 0), $urandom, cut_after, ready_busy,
                resp_busy, r1_prefix, 8'($urandom_range(0, 127)));
    if ($urandom_range(0, 3) == 0) send_idle_bytes($urandom_range(1, 3));
  endtask

  task automatic random_phase(int unsigned target);
    int unsigned start_items;
    start_items = counted_items;
    while (counted_items - start_items < target) random_command();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: bytes while released, cmd0, a rejected app prefix at the
    // field extremes, a byte while selected, a start cut short by another
    send_idle_bytes(2);
    run_command(Cmd0, 1'b0, 32'h0000_0000, 0, 0, 0, 8'h00, 8'h01);
    run_command(6'd63, 1'b1, 32'hFFFF_FFFF, 0, 1, 1, 8'h05, 8'h00);
    send_idle_bytes(1);
    run_command(Cmd8, 1'b0, 32'h0000_01AA, 4, 0, 0, 8'h00, 8'h01);
    wait_drained();

    set_limits(12'd1, 8'd1);
    random_phase(95);
    wait_drained();

    // a limit of zero acts as one
    set_limits(12'd0, 8'd0);
    random_phase(95);
    wait_drained();

    send_idle_pct = 88;
    recv_idle_pct = 24;
    set_limits(12'd4095, 8'd255);
    random_phase(95);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_limits(12'($urandom_range(2, 9)), 8'($urandom_range(2, 6)));
    random_phase(95);
    wait_drained();
    repeat (8) @(posedge clk_i);

    $display("ran %0d commands (%0d cut short by a new start)", sb.n_started, cut_short);
    $display("%0d R1 replies, %0d ready timeouts, %0d rejected prefixes",
             sb.n_resp, sb.n_tout, sb.n_rej);
    $display("%0d replies checked, %0d live exchanges, %0d bytes sent while idle",
             sb.checked, counted_items, idle_bytes);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
